// ===== design/mm4_pkg.sv =====
package mm4_pkg;
    localparam int unsigned DIM = 4;
    localparam int unsigned DEF_DATA_WIDTH = 32;
    localparam int unsigned DEF_FRAC_BITS = 16;
    localparam int unsigned ELEM_W = 32;
    localparam int unsigned POS_W = 4;
endpackage

// ===== design/mm4_if.sv =====
interface mm4_in_if;
    import mm4_pkg::*;
    logic valid;
    logic ready;
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic [POS_W-1:0] position;
    modport source (output valid, a_elem, b_elem, position, input ready);
    modport sink (input valid, a_elem, b_elem, position, output ready);
    modport monitor (input valid, a_elem, b_elem, position, ready);
endinterface

interface mm4_out_if;
    import mm4_pkg::*;
    logic valid;
    logic ready;
    logic signed [ELEM_W-1:0] out_elem;
    logic [POS_W-1:0] out_position;
    logic last;
    logic saturated;
    modport source (output valid, out_elem, out_position, last, saturated, input ready);
    modport sink (input valid, out_elem, out_position, last, saturated, output ready);
    modport monitor (input valid, out_elem, out_position, last, saturated, ready);
endinterface

// ===== design/mm4_cell.sv =====
// one accumulator cell of the chain: adds one product, then hands its sum on
module mm4_cell
    import mm4_pkg::*;
#(
    parameter int unsigned ACC_W = 66
) (
    input  logic                    i_clk,
    input  logic                    i_clear,
    input  logic                    i_add,
    input  logic signed [ACC_W-1:0] i_prod,
    input  logic                    i_load,
    input  logic signed [ACC_W-1:0] i_prev,
    output logic signed [ACC_W-1:0] o_acc
);
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_load) begin
            n_acc = i_prev;
        end else if (i_clear) begin
            n_acc = i_add ? i_prod : '0;
        end else if (i_add) begin
            n_acc = r_acc + i_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule

// ===== design/matrix_multiply_4x4_top.sv =====
// 4x4 signed fixed-point matrix product, out = A * B. Feed words carrying one
// element of A and of B at a row-major position; a word at the last position
// starts the computation on the stored matrices. One shared multiplier does
// DIM*DIM*DIM multiply-accumulates, one per cycle (a registered multiply stage
// feeds the chain). Each of the DIM*DIM sums lives in its own cell of a chain of
// accumulator cells that shifts its finished values toward the output. Results
// leave in row-major order, last flagged on the final word; each is the exact
// sum shifted right FRAC_BITS (toward minus infinity) and saturated, with the
// saturated flag set when clipped. Input is not taken while a product runs or
// results are still draining. Words at positions beyond the matrix are dropped.
module matrix_multiply_4x4_top
    import mm4_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
    input logic  i_clk,
    input logic  i_rst_n,
    mm4_in_if.sink   in_ch,
    mm4_out_if.source out_ch
);
    localparam int unsigned CELLS = DIM * DIM;
    localparam int unsigned IDX_W = $clog2(CELLS);
    localparam int unsigned K_W = $clog2(DIM);
    localparam int unsigned PROD_W = 2 * DATA_WIDTH;
    localparam int unsigned ACC_W = PROD_W + K_W + 1;

    typedef enum logic [1:0] {S_LOAD, S_CALC, S_DRAIN} t_state;

    t_state r_state;
    logic signed [DATA_WIDTH-1:0] r_left [CELLS];
    logic signed [DATA_WIDTH-1:0] r_right [CELLS];
    // compute counters: cell index and inner index
    logic [IDX_W-1:0] r_cell;
    logic [K_W-1:0]   r_k;
    logic r_mul_v, r_mul_first;
    logic [IDX_W-1:0] r_mul_cell;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_WIDTH-1:0] r_opa, r_opb;
    logic r_op_v, r_op_first;
    logic [IDX_W-1:0] r_op_cell;
    logic [IDX_W:0] r_out_cnt;
    logic r_calc_done;

    logic in_fire, out_fire;
    logic [IDX_W-1:0] pos_idx;
    logic signed [ACC_W-1:0] w_acc [CELLS];
    logic signed [ACC_W-1:0] prod_ext;
    logic shift_en;

    assign pos_idx = in_ch.position[IDX_W-1:0];
    assign in_ch.ready = (r_state == S_LOAD);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign shift_en = out_fire;
    assign prod_ext = ACC_W'(r_prod);

    // stores, written on load, read one operand pair per cycle
    always_ff @(posedge i_clk) begin
        if (in_fire && (32'(in_ch.position) < CELLS)) begin
            r_left[pos_idx] <= in_ch.a_elem[DATA_WIDTH-1:0];
            r_right[pos_idx] <= in_ch.b_elem[DATA_WIDTH-1:0];
        end
        r_opa <= r_left[IDX_W'(r_cell / IDX_W'(DIM)) * IDX_W'(DIM) + IDX_W'(r_k)];
        r_opb <= r_right[IDX_W'(r_k) * IDX_W'(DIM) + IDX_W'(r_cell % IDX_W'(DIM))];
        r_prod <= PROD_W'(r_opa) * PROD_W'(r_opb);
        r_mul_cell <= r_op_cell;
        r_mul_first <= r_op_first;
        r_op_cell <= r_cell;
        r_op_first <= (r_k == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cell <= '0;
            r_k <= '0;
            r_op_v <= 1'b0;
            r_mul_v <= 1'b0;
            r_out_cnt <= '0;
            r_calc_done <= 1'b0;
        end else begin
            r_mul_v <= r_op_v;
            // one operand pair issued per cycle until the last one
            r_op_v <= (r_state == S_CALC) && !r_calc_done;
            unique case (r_state)
                S_LOAD: begin
                    if (in_fire && (32'(in_ch.position) == CELLS - 1)) begin
                        r_state <= S_CALC;
                        r_cell <= '0;
                        r_k <= '0;
                        r_calc_done <= 1'b0;
                    end
                end
                S_CALC: begin
                    if (!r_calc_done) begin
                        if (32'(r_k) == DIM - 1) begin
                            r_k <= '0;
                            if (32'(r_cell) == CELLS - 1) r_calc_done <= 1'b1;
                            else r_cell <= r_cell + 1'b1;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else if (!r_op_v && !r_mul_v) begin
                        r_state <= S_DRAIN;
                        r_out_cnt <= '0;
                    end
                end
                S_DRAIN: begin
                    if (out_fire) begin
                        if (32'(r_out_cnt) == CELLS - 1) r_state <= S_LOAD;
                        r_out_cnt <= r_out_cnt + 1'b1;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // chain of cells; cell 0 feeds the output, others shift toward it
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic signed [ACC_W-1:0] prev;
        if (g == CELLS - 1) begin : g_end
            assign prev = '0;
        end else begin : g_mid
            assign prev = w_acc[g+1];
        end
        mm4_cell #(.ACC_W(ACC_W)) u_cell (
            .i_clk  (i_clk),
            .i_clear(r_mul_v && r_mul_first && (r_mul_cell == IDX_W'(g))),
            .i_add  (r_mul_v && (r_mul_cell == IDX_W'(g))),
            .i_prod (prod_ext),
            .i_load (shift_en),
            .i_prev (prev),
            .o_acc  (w_acc[g])
        );
    end

    // scale and saturate the head of the chain
    logic signed [ACC_W-1:0] scaled;
    logic sat_hi, sat_lo;
    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((65'sd1 <<< (DATA_WIDTH-1)) - 1);
    localparam logic signed [ACC_W-1:0] MINV = -MAXV - 1;
    assign scaled = w_acc[0] >>> FRAC_BITS;
    assign sat_hi = scaled > MAXV;
    assign sat_lo = scaled < MINV;

    logic signed [DATA_WIDTH-1:0] res;
    assign res = sat_hi ? MAXV[DATA_WIDTH-1:0]
               : sat_lo ? MINV[DATA_WIDTH-1:0] : scaled[DATA_WIDTH-1:0];

    assign out_ch.valid = (r_state == S_DRAIN);
    assign out_ch.out_elem = ELEM_W'(res);
    assign out_ch.out_position = POS_W'(r_out_cnt[IDX_W-1:0]);
    assign out_ch.last = (32'(r_out_cnt) == CELLS - 1);
    assign out_ch.saturated = sat_hi || sat_lo;

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !in_ch.ready)
        else $error("input taken while busy");
    a_no_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !out_ch.valid)
        else $error("output during load");
    a_calc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && 32'(in_ch.position) == CELLS - 1) |=> (r_state == S_CALC))
        else $error("compute not started");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && out_ch.last) |=> (r_state == S_LOAD))
        else $error("drain did not end");
endmodule
